@@ hw/rtl/sorted_set_priority_queue_assert.svh @@
// Assertion macros shared by the priority queue RTL.
// No dependencies; the user must have clk_i and rst_ni in scope.
`ifndef SORTED_SET_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_SET_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define SSPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sspq_pkg.sv @@
// Shared types and constants for the sorted-set priority queue.
// No dependencies.
`default_nettype none

package sspq_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned StatW  = 3;
  localparam logic [KeyW-1:0] SentinelKey = '1;

  typedef enum logic [StatW-1:0] {
    STS_ADDED   = 3'd0,
    STS_DUP     = 3'd1,
    STS_FULL    = 3'd2,
    STS_REMOVED = 3'd3,
    STS_EMPTY   = 3'd4
  } status_e;

  typedef enum logic {
    ACT_ADD = 1'b0,
    ACT_POP = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_FIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic move;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic move_needed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/sspq_ctrl.sv @@
// Sequencing state machine for the priority queue.
// Depends on sspq_pkg and the assertion macro header.
`default_nettype none

module sspq_ctrl
  import sspq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

`include "sorted_set_priority_queue_assert.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = sts_i.move_needed ? S_MOVE : S_FIN;
      end
      S_MOVE: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    s_tready_o   = (state_q == S_IDLE);
    cmd_o.load   = (state_q == S_IDLE) && s_tvalid_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.decide = (state_q == S_DECIDE);
    cmd_o.move   = (state_q == S_MOVE);
    cmd_o.emit   = (state_q == S_FIN) && sts_i.out_free;
  end

  `SSPQ_ASSERT_IMP(a_move_after_decide, state_q == S_MOVE, $past(state_q) == S_DECIDE, "move without decide")
  `SSPQ_ASSERT_NXT(a_load_starts_scan, cmd_o.load, state_q == S_SCAN, "load did not start scan")
  `SSPQ_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd_o), "several commands at once")

endmodule

`default_nettype wire

@@ hw/rtl/sspq_dpath.sv @@
// Datapath: key memory, fill count, scan compare, result register.
// Depends on sspq_pkg and the assertion macro header.
`default_nettype none

module sspq_dpath
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic            in_action_i,
  input  logic [KeyW-1:0] in_key_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [StatW-1:0] out_status_o,
  output logic [KeyW-1:0] out_key_o
);

`include "sorted_set_priority_queue_assert.svh"

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // keys are kept packed in slots 0 .. count-1
  logic [KeyW-1:0] mem [CAPACITY];

  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            action_q;
  logic [KeyW-1:0] key_q;
  logic            rd_vld_q;
  logic [AW-1:0]   rd_idx_q;
  logic [KeyW-1:0] rd_data_q;
  logic            dup_q, any_q;
  logic [KeyW-1:0] min_q;
  logic [AW-1:0]   min_idx_q;
  status_e         res_status_q, res_status_d;
  logic [KeyW-1:0] res_key_q, res_key_d;
  logic            out_valid_q;
  logic [StatW-1:0] out_status_q;
  logic [KeyW-1:0] out_key_q;

  logic            scan_rd, rd_en, wr_en, add_ok, is_full, is_empty, take_min;
  logic [AW-1:0]   rd_addr, wr_addr, last_addr;
  logic [KeyW-1:0] wr_data;

  assign is_full   = (count_q == CW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign last_addr = AW'(count_q - CW'(1));
  assign scan_rd   = cmd_i.scan && (idx_q != count_q);
  assign add_ok    = (action_q == ACT_ADD) && !dup_q && (key_q != SentinelKey) && !is_full;
  assign take_min  = rd_vld_q && (!any_q || (rd_data_q < min_q));

  assign sts_o.scan_done   = (idx_q == count_q) && !rd_vld_q;
  assign sts_o.move_needed = (action_q == ACT_POP) && !is_empty;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign rd_en   = scan_rd || (cmd_i.decide && sts_o.move_needed);
  assign rd_addr = scan_rd ? idx_q[AW-1:0] : last_addr;
  assign wr_en   = (cmd_i.decide && add_ok) || cmd_i.move;
  assign wr_addr = cmd_i.move ? min_idx_q : count_q[AW-1:0];
  assign wr_data = cmd_i.move ? rd_data_q : key_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.decide && add_ok) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.decide && sts_o.move_needed) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (scan_rd) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_comb begin
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    if (cmd_i.decide) begin
      res_key_d = '0;
      if (action_q == ACT_ADD) begin
        priority if ((key_q == SentinelKey) || dup_q) res_status_d = STS_DUP;
        else if (is_full) res_status_d = STS_FULL;
        else res_status_d = STS_ADDED;
      end else if (is_empty) begin
        res_status_d = STS_EMPTY;
      end else begin
        res_status_d = STS_REMOVED;
        res_key_d    = min_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= scan_rd;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and scan flags; flags are reloaded on every item
  always_ff @(posedge clk_i) begin
    rd_idx_q     <= idx_q[AW-1:0];
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    if (cmd_i.load) begin
      action_q <= in_action_i;
      key_q    <= in_key_i;
      dup_q    <= 1'b0;
      any_q    <= 1'b0;
    end else if (rd_vld_q) begin
      any_q <= 1'b1;
      if (rd_data_q == key_q) dup_q <= 1'b1;
    end
    if (take_min) begin
      min_q     <= rd_data_q;
      min_idx_q <= rd_idx_q;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;

  `SSPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "fill count above capacity")
  `SSPQ_ASSERT_NXT(a_add_grows, cmd_i.decide && add_ok, count_q == $past(count_q) + CW'(1), "add did not grow count")
  `SSPQ_ASSERT_IMP(a_full_only_full, cmd_i.emit && (res_status_q == STS_FULL), is_full, "full reported with room left")
  `SSPQ_ASSERT_IMP(a_idx_bound, cmd_i.scan, idx_q <= count_q, "scan index past fill count")

endmodule

`default_nettype wire

@@ hw/rtl/sorted_set_priority_queue.sv @@
// Sorted-set priority queue, top level: controller plus datapath.
// Depends on sspq_pkg, sspq_ctrl, sspq_dpath.
// Usage: one input item (s_*) is one operation. s_tuser is the action
//   (0 add key, 1 remove smallest key); s_tdata is the key, ignored for a
//   remove. A key already held, or the all-ones key, is refused as a
//   duplicate; an add of a new key to a full store is refused as full.
//   One result item (m_*) per input item, in order: m_tuser is the status
//   (0 added, 1 duplicate, 2 full, 3 removed, 4 empty), m_tdata the
//   removed key for status 3, else zero.
// Throughput: one item at a time, set by a scan of the key memory at
//   one entry per cycle; a remove that finds a key adds a slot move
//   after the scan. The next item is accepted at the earliest in the
//   cycle after the result is loaded. s_tready is high only while idle.
// Reset: rst_ni clears the fill count and control state; the queue comes
//   up empty and ready at once, with no clearing pass.
// Stalls: the result sits in an output register. While m_tready is low
//   the next item is still accepted and processed; it then waits for the
//   register before it is delivered.
`default_nettype none

module sorted_set_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [KeyW-1:0]  s_tdata,   // [31:0] key
  input  logic             s_tuser,   // [0] action
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [KeyW-1:0]  m_tdata,   // [31:0] min_key
  output logic [StatW-1:0] m_tuser    // [2:0] status
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, scan, decide, optional slot move, deliver
  sspq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // key memory kept packed; a removal refills its slot from the last key
  sspq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_action_i  (s_tuser),
    .in_key_i     (s_tdata),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_status_o (m_tuser),
    .out_key_o    (m_tdata)
  );

endmodule

`default_nettype wire
